@@ rtl/nd_strided_address_generator_core_assert.svh @@
// Assertion macros used by the address generator core.
`ifndef ND_STRIDED_ADDRESS_GENERATOR_CORE_ASSERT_SVH
`define ND_STRIDED_ADDRESS_GENERATOR_CORE_ASSERT_SVH

// Check under reset qualification.
`define NDSAG_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check at every edge, reset included.
`define NDSAG_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/ndsag_pkg.sv @@
`timescale 1ns / 1ps

package ndsag_pkg;

	localparam int INDEX_WIDTH      = 32;
	localparam int COUNT_WIDTH      = 16;
	localparam int NUM_DIMS         = 4;
	localparam int DATA_WIDTH       = 32;
	localparam int OUT_WIDTH        = 32;
	localparam int STRIDE_WIDTH     = 32;
	localparam int BASE_WIDTH       = 32;
	localparam int SIZE_FIELD_WIDTH = 16;
	localparam int SIZES_WIDTH      = 64;
	localparam int CFG_INDEX_WIDTH  = 3;
	localparam int CFG_DATA_WIDTH   = 64;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_BASE_INDEX  = 3'd0,
		REG_DIM_SIZES   = 3'd1,
		REG_STRIDE_DIM0 = 3'd2,
		REG_STRIDE_DIM1 = 3'd3,
		REG_STRIDE_DIM2 = 3'd4,
		REG_STRIDE_DIM3 = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic advance;
		logic carry_in;
		logic stride_we;
	} dim_ctl_t;

	typedef struct packed {
		logic                   fin;
		logic [INDEX_WIDTH-1:0] term;
	} dim_stat_t;

	typedef struct packed {
		logic [OUT_WIDTH-1:0]  linear_position;
		logic [OUT_WIDTH-1:0]  strided_index;
		logic [DATA_WIDTH-1:0] element;
		logic                  last;
		logic                  valid;
	} result_t;

endpackage

@@ rtl/nd_strided_address_generator_core.sv @@
// Four-dimensional strided address generator.
// Slave stream: s_tdata carries one 32-bit element per transfer.
// Master stream: m_tdata carries the element, its strided index and its
// linear position; m_tlast marks the element that ends the descriptor and
// m_tuser is high when the index is valid (all sizes nonzero).
// Config channel: cfg_index selects base, packed sizes or one of four
// strides, cfg_data holds the value; it is always ready and should only be
// written while no transfer is in flight.
// The output is valid in the cycle after the input transfer, and one element
// is taken every cycle while the receiver does not stall. Index terms are kept
// per dimension and stepped by their stride, so the path to the output register
// is one multi-operand add; a stride write reloads its term with one registered multiply.
// Reset clears all counters and the output valid flag and loads base 0,
// every size 1 and every stride 1.
// When the receiver stalls, the output holds and s_tready drops until the
// held result is taken; it rises again in the cycle the result leaves.
`timescale 1ns / 1ps
`include "nd_strided_address_generator_core_assert.svh"

module nd_strided_address_generator_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [ndsag_pkg::DATA_WIDTH-1:0]       s_tdata,   // element_in
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// element_out, strided_index, linear_position
	output logic [ndsag_pkg::DATA_WIDTH+2*ndsag_pkg::OUT_WIDTH-1:0] m_tdata,
	output logic                                   m_tlast,
	output logic                                   m_tuser,   // index_valid
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [ndsag_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [ndsag_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

	localparam int ND = ndsag_pkg::NUM_DIMS;

	logic                                  s_accept;
	logic                                  cfg_we;
	logic [ndsag_pkg::BASE_WIDTH-1:0]      base_q;
	logic [ndsag_pkg::SIZES_WIDTH-1:0]     sizes_q;
	logic [ndsag_pkg::OUT_WIDTH-1:0]       position_q;
	logic [ndsag_pkg::COUNT_WIDTH-1:0]     size [ND];
	ndsag_pkg::dim_ctl_t                   dim_ctl [ND];
	ndsag_pkg::dim_stat_t                  dim_stat [ND];
	logic [ND-1:0]                         carry;
	logic                                  empty;
	logic                                  last;
	logic                                  advance;
	logic [ndsag_pkg::INDEX_WIDTH-1:0]     index_sum;
	ndsag_pkg::result_t                    result_d;
	ndsag_pkg::result_t                    result_q;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign s_accept  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			sizes_q <= ndsag_pkg::SIZES_WIDTH'(64'h0001_0001_0001_0001);
		end else if (cfg_we) begin
			if (cfg_index == ndsag_pkg::REG_BASE_INDEX) begin
				base_q <= cfg_data[ndsag_pkg::BASE_WIDTH-1:0];
			end
			if (cfg_index == ndsag_pkg::REG_DIM_SIZES) begin
				sizes_q <= cfg_data[ndsag_pkg::SIZES_WIDTH-1:0];
			end
		end
	end

	for (genvar d = 0; d < ND; d++) begin : g_dim
		assign size[d] = sizes_q[d*ndsag_pkg::SIZE_FIELD_WIDTH +: ndsag_pkg::COUNT_WIDTH];
		assign dim_ctl[d].advance   = advance;
		assign dim_ctl[d].carry_in  = carry[d];
		assign dim_ctl[d].stride_we = cfg_we && (cfg_index ==
			ndsag_pkg::CFG_INDEX_WIDTH'(int'(ndsag_pkg::REG_STRIDE_DIM0) + d));

		ndsag_dim u_dim (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (dim_ctl[d]),
			.stride_data (cfg_data[ndsag_pkg::STRIDE_WIDTH-1:0]),
			.size        (size[d]),
			.stat        (dim_stat[d])
		);
	end

	always_comb begin
		empty     = 1'b0;
		last      = 1'b1;
		carry[0]  = 1'b1;
		index_sum = ndsag_pkg::INDEX_WIDTH'(base_q);
		for (int d = 0; d < ND; d++) begin
			if (size[d] == '0) begin
				empty = 1'b1;
			end
			last      = last && dim_stat[d].fin;
			index_sum = index_sum + dim_stat[d].term;
			if (d > 0) begin
				carry[d] = carry[d-1] && dim_stat[d-1].fin;
			end
		end
	end

	assign advance = s_accept && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
		end else if (advance) begin
			position_q <= last ? '0 : position_q + ndsag_pkg::OUT_WIDTH'(1);
		end
	end

	always_comb begin
		result_d.element         = s_tdata;
		result_d.valid           = !empty;
		result_d.last            = !empty && last;
		result_d.strided_index   = empty ? '0 : ndsag_pkg::OUT_WIDTH'(index_sum);
		result_d.linear_position = empty ? '0 : position_q;
	end

	ndsag_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (s_tvalid),
		.result_in  (result_d),
		.in_ready   (s_tready),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.result_out (result_q)
	);

	assign m_tdata = {result_q.linear_position, result_q.strided_index, result_q.element};
	assign m_tlast = result_q.last;
	assign m_tuser = result_q.valid;

	`NDSAG_ASSERT_RST(a_accept_shows, (s_tvalid && s_tready) |=> m_tvalid, "accepted transfer lost")
	`NDSAG_ASSERT_RST(a_empty_zero, (m_tvalid && !m_tuser) |-> (!m_tlast && m_tdata[95:32] == '0), "empty descriptor result not cleared")
	`NDSAG_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !m_tvalid, "output valid during reset")

endmodule

@@ rtl/ndsag_dim.sv @@
`timescale 1ns / 1ps

module ndsag_dim (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ndsag_pkg::dim_ctl_t                  ctl,
	input  logic [ndsag_pkg::STRIDE_WIDTH-1:0]   stride_data,
	input  logic [ndsag_pkg::COUNT_WIDTH-1:0]    size,
	output ndsag_pkg::dim_stat_t                 stat
);

	logic [ndsag_pkg::COUNT_WIDTH-1:0]                         counter_q;
	logic [ndsag_pkg::INDEX_WIDTH-1:0]                         term_q;
	logic [ndsag_pkg::STRIDE_WIDTH-1:0]                        stride_q;
	logic [ndsag_pkg::COUNT_WIDTH+ndsag_pkg::STRIDE_WIDTH-1:0] reload_prod;
	logic                                                      fin;

	// Rebuild the term from the held counter when the stride changes.
	assign reload_prod = counter_q * stride_data;
	assign fin = counter_q >= size - ndsag_pkg::COUNT_WIDTH'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			term_q    <= '0;
			stride_q  <= ndsag_pkg::STRIDE_WIDTH'(1);
		end else if (ctl.stride_we) begin
			stride_q <= stride_data;
			term_q   <= ndsag_pkg::INDEX_WIDTH'(reload_prod);
		end else if (ctl.advance && ctl.carry_in) begin
			if (fin) begin
				counter_q <= '0;
				term_q    <= '0;
			end else begin
				counter_q <= counter_q + ndsag_pkg::COUNT_WIDTH'(1);
				term_q    <= term_q + ndsag_pkg::INDEX_WIDTH'(stride_q);
			end
		end
	end

	assign stat.fin  = fin;
	assign stat.term = term_q;

endmodule

@@ rtl/ndsag_out_reg.sv @@
`timescale 1ns / 1ps

module ndsag_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  ndsag_pkg::result_t result_in,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output ndsag_pkg::result_t result_out
);

	logic               valid_q;
	ndsag_pkg::result_t result_q;

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_ready) begin
			result_q <= result_in;
		end
	end

	assign out_valid  = valid_q;
	assign result_out = result_q;

endmodule

@@ test/nd_strided_address_generator_core_test.sv @@
`timescale 1ns / 1ps

module nd_strided_address_generator_core_test;
	import ndsag_pkg::*;

	localparam int CYCLE_LIMIT = 250000;
	localparam int ELEMENT_TOTAL = 1570;
	localparam int STEADY_FROM = 1380;
	localparam int LONG_HOLD_AT = 600;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED_LO = 3'd6;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED_HI = 3'd7;

	class address_scoreboard;
		logic [BASE_WIDTH-1:0] base;
		logic [SIZES_WIDTH-1:0] sizes;
		logic [STRIDE_WIDTH-1:0] stride[NUM_DIMS];
		logic [COUNT_WIDTH-1:0] count[NUM_DIMS];
		logic [OUT_WIDTH-1:0] position;
		result_t awaited[$];
		int errors;

		function new();
			base = '0;
			sizes = {NUM_DIMS{16'd1}};
			for (int d = 0; d < NUM_DIMS; d++) begin
				stride[d] = 32'd1;
				count[d] = '0;
			end
			position = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
			case (idx)
				REG_BASE_INDEX: base = val[BASE_WIDTH-1:0];
				REG_DIM_SIZES: sizes = val[SIZES_WIDTH-1:0];
				REG_STRIDE_DIM0, REG_STRIDE_DIM1, REG_STRIDE_DIM2, REG_STRIDE_DIM3:
					stride[idx - REG_STRIDE_DIM0] = val[STRIDE_WIDTH-1:0];
				default: ;
			endcase
		endfunction

		function logic [COUNT_WIDTH-1:0] size_of(int d);
			return sizes[SIZE_FIELD_WIDTH*d +: COUNT_WIDTH];
		endfunction

		function void note_element(logic [DATA_WIDTH-1:0] elem);
			result_t r;
			logic [INDEX_WIDTH-1:0] idx;
			bit empty;
			bit last;
			bit carry;
			r.element = elem;
			empty = 0;
			for (int d = 0; d < NUM_DIMS; d++)
				if (size_of(d) == 0)
					empty = 1;
			if (empty) begin
				r.strided_index = '0;
				r.linear_position = '0;
				r.last = 1'b0;
				r.valid = 1'b0;
				awaited.push_back(r);
				return;
			end
			idx = base;
			last = 1;
			for (int d = 0; d < NUM_DIMS; d++) begin
				idx = idx + INDEX_WIDTH'(count[d]) * stride[d];
				if (count[d] < size_of(d) - 1'b1)
					last = 0;
			end
			r.strided_index = idx;
			r.linear_position = position;
			r.last = last;
			r.valid = 1'b1;
			awaited.push_back(r);
			if (last) begin
				for (int d = 0; d < NUM_DIMS; d++)
					count[d] = '0;
				position = '0;
			end else begin
				carry = 1;
				for (int d = 0; d < NUM_DIMS && carry; d++) begin
					if (count[d] >= size_of(d) - 1'b1) begin
						count[d] = '0;
					end else begin
						count[d] = count[d] + 1'b1;
						carry = 0;
					end
				end
				position = position + 1'b1;
			end
		endfunction

		function void check_result(logic [DATA_WIDTH+2*OUT_WIDTH-1:0] data, logic tl, logic tu);
			result_t want;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected transfer: data %h last %b user %b", data, tl, tu);
				return;
			end
			want = awaited.pop_front();
			if (data[DATA_WIDTH-1:0] !== want.element
					|| data[DATA_WIDTH +: OUT_WIDTH] !== want.strided_index
					|| data[DATA_WIDTH+OUT_WIDTH +: OUT_WIDTH] !== want.linear_position
					|| tl !== want.last || tu !== want.valid) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: expected elem %h idx %h pos %h last %b valid %b,",
						" got elem %h idx %h pos %h last %b valid %b"},
						want.element, want.strided_index, want.linear_position, want.last,
						want.valid, data[DATA_WIDTH-1:0], data[DATA_WIDTH +: OUT_WIDTH],
						data[DATA_WIDTH+OUT_WIDTH +: OUT_WIDTH], tl, tu);
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [DATA_WIDTH-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [DATA_WIDTH+2*OUT_WIDTH-1:0] m_tdata;
	logic m_tlast;
	logic m_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [CFG_DATA_WIDTH-1:0] cfg_data;

	address_scoreboard sb = new();
	int sent = 0;
	int cycles = 0;
	bit no_idle = 0;
	bit long_hold_req = 0;
	bit long_hold_done = 0;

	nd_strided_address_generator_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int hold;
		hold = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 0;
				hold = LONG_HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (arst_n && !no_idle && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(1, 9) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= arst_n;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tlast, m_tuser);
	end

	task automatic send_element(input logic [DATA_WIDTH-1:0] elem);
		int gap;
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 9);
			s_tvalid <= 1'b0;
			s_tdata <= $urandom;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= elem;
		do @(posedge clk); while (!s_tready);
		sb.note_element(elem);
		sent++;
	endtask

	// hold the stream until every transfer has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
			input logic [CFG_DATA_WIDTH-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
	endtask

	task automatic end_config();
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_word();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return 32'h0;
		if (r == 1)
			return 32'hFFFF_FFFF;
		if (r < 4)
			return $urandom_range(0, 16);
		return $urandom;
	endfunction

	function automatic logic [15:0] pick_size();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return 16'h0;
		if (r == 1)
			return 16'hFFFF;
		if (r == 2)
			return 16'($urandom);
		return 16'($urandom_range(1, 3));
	endfunction

	function automatic logic [DATA_WIDTH-1:0] pick_data();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
		return $urandom;
	endfunction

	task automatic random_setup();
		logic [SIZES_WIDTH-1:0] sz;
		if ($urandom_range(0, 3) != 0)
			put_reg(REG_BASE_INDEX, {$urandom, pick_word()});
		if ($urandom_range(0, 3) != 0) begin
			if ($urandom_range(0, 9) == 0)
				sz = {$urandom, $urandom};
			else
				sz = {pick_size(), pick_size(), pick_size(), pick_size()};
			put_reg(REG_DIM_SIZES, sz);
		end
		if ($urandom_range(0, 3) != 0)
			put_reg(REG_STRIDE_DIM0, {$urandom, pick_word()});
		if ($urandom_range(0, 3) != 0)
			put_reg(REG_STRIDE_DIM1, {$urandom, pick_word()});
		if ($urandom_range(0, 3) != 0)
			put_reg(REG_STRIDE_DIM2, {$urandom, pick_word()});
		if ($urandom_range(0, 3) != 0)
			put_reg(REG_STRIDE_DIM3, {$urandom, pick_word()});
		if ($urandom_range(0, 7) == 0)
			put_reg($urandom_range(0, 1) ? REG_UNUSED_HI : REG_UNUSED_LO, {$urandom, $urandom});
		end_config();
	endtask

	initial begin
		int n;
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_BASE_INDEX;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		no_idle = 1;
		send_element(32'h0);
		send_element(32'hFFFF_FFFF);

		settle();
		put_reg(REG_UNUSED_LO, 64'hFFFF_FFFF_FFFF_FFFF);
		put_reg(REG_UNUSED_HI, 64'h0);
		end_config();
		send_element(32'h7F80_0000);

		settle();
		put_reg(REG_BASE_INDEX, 64'hFFFF_FFFF);
		put_reg(REG_DIM_SIZES, 64'h0001_0001_0002_0003);
		put_reg(REG_STRIDE_DIM0, 64'hFFFF_FFFF);
		put_reg(REG_STRIDE_DIM1, 64'hFFFF_FFFF);
		put_reg(REG_STRIDE_DIM2, 64'hFFFF_FFFF);
		put_reg(REG_STRIDE_DIM3, 64'hFFFF_FFFF);
		end_config();
		repeat (7) send_element(pick_data());

		settle();
		put_reg(REG_DIM_SIZES, 64'h0001_0000_0001_0001);
		end_config();
		send_element(32'h7F80_0000);
		send_element(32'hFFFF_FFFF);

		settle();
		put_reg(REG_DIM_SIZES, 64'h0);
		end_config();
		send_element(32'h8000_0000);

		settle();
		put_reg(REG_BASE_INDEX, 64'h0);
		put_reg(REG_DIM_SIZES, 64'hFFFF_FFFF_FFFF_FFFF);
		put_reg(REG_STRIDE_DIM0, 64'h1234_5678);
		put_reg(REG_STRIDE_DIM1, 64'h8000_0001);
		put_reg(REG_STRIDE_DIM2, 64'h0000_0100);
		put_reg(REG_STRIDE_DIM3, 64'hFFFF_0000);
		end_config();
		repeat (3) send_element(pick_data());

		// shrink below the running counters so the transfer wraps early
		settle();
		put_reg(REG_DIM_SIZES, 64'h0001_0001_0001_0002);
		end_config();
		repeat (2) send_element(pick_data());

		settle();
		put_reg(REG_BASE_INDEX, {32'h0, $urandom});
		put_reg(REG_STRIDE_DIM0, 64'h0);
		put_reg(REG_STRIDE_DIM1, 64'h0);
		end_config();
		repeat (2) send_element(pick_data());

		while (sent < ELEMENT_TOTAL) begin
			settle();
			no_idle = (sent >= STEADY_FROM) || ($urandom_range(0, 3) == 0);
			random_setup();
			n = $urandom_range(10, 60);
			for (int i = 0; i < n && sent < ELEMENT_TOTAL; i++) begin
				if (!long_hold_done && sent >= LONG_HOLD_AT && i == 0) begin
					long_hold_done = 1;
					long_hold_req = 1;
				end
				send_element(pick_data());
			end
		end

		settle();
		repeat (4) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ndsag_pkg.sv
rtl/ndsag_dim.sv
rtl/ndsag_out_reg.sv
rtl/nd_strided_address_generator_core.sv
test/nd_strided_address_generator_core_test.sv
